/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define SPMQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, kept active through reset.
`define SPMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spmq_pkg.sv */
// Package: shared types and constants of the strict priority message queue.
package spmq_pkg;

   typedef enum logic [1:0] {
      KIND_ENQ    = 2'd0,
      KIND_DEQ    = 2'd1,
      KIND_PEEK   = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   localparam int KIND_W        = 2;
   localparam int PRIO_W        = 2;
   localparam int MESSAGE_W     = 32;
   localparam int COUNT_W       = 9;
   localparam int CAPACITY_INIT = 256;

   localparam int DEF_LEVELS       = 4;
   localparam int DEF_LEVEL_DEPTH  = 256;
   localparam int DEF_PAYLOAD_BITS = 32;

endpackage

/* rtl/strict_priority_message_queue.sv */
// Top level: strict priority message queue, one FIFO region per level in a shared RAM.
// The response strobes in the cycle after a request is taken, as the RAM read is registered.
// Throughput: one request per cycle; busy stays low, as pointers and counts update
// at the accepting edge and the payload RAM has one write and one read port.
// Reset (synchronous, active high) empties every level and sets the capacity to 256;
// payload RAM contents are not cleared, only written entries are ever read.
module strict_priority_message_queue #(
   parameter int LEVELS       = spmq_pkg::DEF_LEVELS,
   parameter int LEVEL_DEPTH  = spmq_pkg::DEF_LEVEL_DEPTH,
   parameter int PAYLOAD_BITS = spmq_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [spmq_pkg::KIND_W-1:0]    req_kind,
   input  logic [spmq_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [spmq_pkg::MESSAGE_W-1:0] req_message,
   // response channel
   output logic                           rsp_valid,
   output logic                           rsp_ok,
   output logic [spmq_pkg::MESSAGE_W-1:0] rsp_message_out,
   output logic [spmq_pkg::COUNT_W-1:0]   rsp_total_count,
   output logic [spmq_pkg::COUNT_W-1:0]   rsp_level_count,
   output logic                           rsp_all_empty,
   // capacity register
   input  logic                           csr_wr_en,
   input  logic [spmq_pkg::COUNT_W-1:0]   csr_wr_data
);

   import spmq_pkg::*;

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int RAM_D  = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W = $clog2(RAM_D);

   // Per-level bookkeeping: small, each entry read at a decoded level index.
   logic [PTR_W-1:0]   head_ff  [LEVELS];
   logic [PTR_W-1:0]   head_in  [LEVELS];
   logic [PTR_W-1:0]   tail_ff  [LEVELS];
   logic [PTR_W-1:0]   tail_in  [LEVELS];
   logic [CNT_W-1:0]   count_ff [LEVELS];
   logic [CNT_W-1:0]   count_in [LEVELS];
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] total_in;
   logic [COUNT_W-1:0] capacity_ff;
   logic [COUNT_W-1:0] capacity_in;

   // Response registers.
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic               rsp_hit_ff;
   logic               rsp_hit_in;
   logic [COUNT_W-1:0] rsp_total_ff;
   logic [COUNT_W-1:0] rsp_level_ff;
   logic [COUNT_W-1:0] rsp_level_in;
   logic               rsp_empty_ff;

   // Request decode.
   kind_type           kind;
   logic               accept;
   logic               prio_ok;
   logic [LVL_W-1:0]   prio_idx;
   logic [LVL_W-1:0]   first_idx;
   logic               found;
   logic               enq_go;
   logic               pop;
   logic [PTR_W-1:0]   head_sel;
   logic [PTR_W-1:0]   tail_sel;

   // RAM port signals.
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [PAYLOAD_BITS-1:0] ram_wr_data;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;

   // Never stall: every request completes its bookkeeping at the accepting edge.
   assign busy = 1'b0;

   always_comb begin
      accept   = start && !busy;
      kind     = kind_type'(req_kind);
      prio_ok  = 32'(req_priority_req) < 32'(LEVELS);
      prio_idx = LVL_W'(req_priority_req);

      // Priority encoder: lowest-numbered level that holds a message wins.
      found     = 1'b0;
      first_idx = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            found     = 1'b1;
            first_idx = LVL_W'(i);
         end
      end

      head_sel = head_ff[first_idx];
      tail_sel = prio_ok ? tail_ff[prio_idx] : '0;

      // Admit an enqueue only under both the shared capacity and the level's room.
      enq_go = accept && (kind == KIND_ENQ) && prio_ok && (total_ff < capacity_ff) &&
               (count_ff[prio_idx] < CNT_W'(LEVEL_DEPTH));
      rsp_hit_in = accept && ((kind == KIND_DEQ) || (kind == KIND_PEEK)) && found;
      pop        = rsp_hit_in && (kind == KIND_DEQ);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      total_in = total_ff;

      // Advance the tail and bump the counts on an admitted enqueue.
      if (enq_go) begin
         tail_in[prio_idx]  = (tail_sel == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail_sel + 1'b1;
         count_in[prio_idx] = count_ff[prio_idx] + 1'b1;
         total_in           = total_ff + 1'b1;
      end

      // Drop the head on a dequeue; a peek leaves the level untouched.
      if (pop) begin
         head_in[first_idx]  = (head_sel == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head_sel + 1'b1;
         count_in[first_idx] = count_ff[first_idx] - 1'b1;
         total_in            = total_ff - 1'b1;
      end

      rsp_level_in = prio_ok ? COUNT_W'(count_in[prio_idx]) : '0;

      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

      // Each level owns a contiguous region of LEVEL_DEPTH words.
      ram_wr_en   = enq_go;
      ram_wr_addr = ADDR_W'(prio_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_sel);
      ram_wr_data = PAYLOAD_BITS'(req_message);
      ram_rd_en   = rsp_hit_in;
      ram_rd_addr = ADDR_W'(first_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         total_ff     <= '0;
         capacity_ff  <= COUNT_W'(CAPACITY_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= accept;
      end
   end

   // Response payload: no reset, qualified by the strobe.
   always_ff @(posedge clock) begin
      rsp_ok_ff    <= enq_go || rsp_hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_total_ff <= total_in;
      rsp_level_ff <= rsp_level_in;
      rsp_empty_ff <= (total_in == '0);
   end

   spmq_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (RAM_D)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_message_out = rsp_hit_ff ? MESSAGE_W'(ram_rd_data) : '0;
   assign rsp_total_count = rsp_total_ff;
   assign rsp_level_count = rsp_level_ff;
   assign rsp_all_empty   = rsp_empty_ff;

endmodule

/* rtl/spmq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module spmq_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/spmq_checker.sv */
// Checker: port-level assertions on the strict priority message queue, bound to the top.
`include "assert_macros.svh"

module spmq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [spmq_pkg::KIND_W-1:0]    req_kind,
   input logic                           rsp_valid,
   input logic                           rsp_ok,
   input logic [spmq_pkg::MESSAGE_W-1:0] rsp_message_out,
   input logic [spmq_pkg::COUNT_W-1:0]   rsp_total_count,
   input logic                           rsp_all_empty
);

   import spmq_pkg::*;

   logic req_fire;
   logic total_zero;
   logic msg_zero;
   logic no_data_kind;

   assign req_fire     = start && !busy;
   assign total_zero   = (rsp_total_count == '0);
   assign msg_zero     = (rsp_message_out == '0);
   assign no_data_kind = (req_kind == KIND_ENQ) || (req_kind == KIND_STATUS);

   `SPMQ_ASSERT(a_rsp_follows_req, clock, reset, req_fire |=> rsp_valid, "missing response")
   `SPMQ_ASSERT(a_rsp_needs_req, clock, reset, rsp_valid |-> $past(req_fire), "stray response")
   `SPMQ_ASSERT(a_empty_flag, clock, reset, rsp_valid |-> (rsp_all_empty == total_zero), "bad empty")
   `SPMQ_ASSERT(a_fail_zero_msg, clock, reset, (rsp_valid && !rsp_ok) |-> msg_zero, "data on fail")
   `SPMQ_ASSERT(a_enq_no_msg, clock, reset, (rsp_valid && $past(no_data_kind)) |-> msg_zero, "data")

endmodule

bind strict_priority_message_queue spmq_checker u_spmq_checker (.*);
